[rtl/core/calendar_time_add_subtract_assert.svh]
// assertion macros shared by the calendar time add/subtract block
`ifndef CALENDAR_TIME_ADD_SUBTRACT_ASSERT_SVH
`define CALENDAR_TIME_ADD_SUBTRACT_ASSERT_SVH
`ifndef SYNTHESIS
`define CTA_ASSERT_IMP(lbl, clk, rst, a, b) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed");
`define CTA_ASSERT_NXT(lbl, clk, rst, a, b) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed");
`else
`define CTA_ASSERT_IMP(lbl, clk, rst, a, b)
`define CTA_ASSERT_NXT(lbl, clk, rst, a, b)
`endif
`endif

[rtl/core/cta_pkg.sv]
// shared types, constants and calendar helpers for the time add/subtract block
`timescale 1ns / 1ps
package cta_pkg;

   localparam logic [16:0] SecsPerDay  = 17'd86400;
   localparam logic [16:0] SecsPerHour = 17'd3600;
   localparam logic [16:0] SecsPerMin  = 17'd60;
   localparam logic [16:0] DaysPerCyc  = 17'd1461;
   // reciprocals: day is (x >> 7) / 675, hour is (x >> 4) / 225, minute is (x >> 2) / 15
   localparam logic [25:0] RecipDay    = 26'd50903317;
   localparam logic [13:0] RecipHour   = 14'd9321;
   localparam logic [10:0] RecipMin    = 11'd1093;
   localparam int          ReqDataW    = 80;
   localparam int          RspDataW    = 56;

   typedef enum logic [0:0] {
      OP_ADD = 1'b0,
      OP_SUB = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      DIV_DAY = 2'd0,
      DIV_HR  = 2'd1,
      DIV_MIN = 2'd2
   } div_sel_type;

   typedef struct packed {
      logic        load;
      logic        div_step;
      div_sel_type div_sel;
      logic        adj;
      logic        cyc;
      logic        step;
      logic        hr_init;
      logic        mn_init;
      logic        out_load;
   } cmd_type;

   typedef struct packed {
      logic div_last;
      logic cyc_more;
      logic step_more;
   } stat_type;

   // days in a month under the divisible-by-4 leap rule
   function automatic logic [4:0] month_len(input logic [3:0] mon, input logic [15:0] yr);
      logic [4:0] len;
      case (mon)
         4'd2:                      len = (yr[1:0] == 2'd0) ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
         default:                   len = 5'd31;
      endcase
      return len;
   endfunction

endpackage

[rtl/core/calendar_time_add_subtract.sv]
// top level: moves a calendar time point by a second count, forward or back
// sequence: day split, remainder merge, four-year hops, single day steps, hour split,
//   minute split and result load
// one item at a time: a new item is taken only when the sequencer is idle, which
// includes while the previous result waits in the output register
// reset (synchronous, active high) clears the sequencer and the output valid
`timescale 1ns / 1ps
module calendar_time_add_subtract (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // command
   input  logic                          req_tuser,
   // seconds_delta, year_in, month_in, day_in, weekday_in, hour_in, minute_in,
   // second_in, zero pad
   input  logic [cta_pkg::ReqDataW-1:0]  req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // year_out, month_out, day_out, weekday_out, hour_out, minute_out, second_out,
   // pm_flag, hour_twelve, zero pad
   output logic [cta_pkg::RspDataW-1:0]  rsp_tdata
);

   cta_pkg::cmd_type  cmd;
   cta_pkg::stat_type stat;

   cta_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   cta_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_tuser (req_tuser),
      .req_tdata (req_tdata),
      .rsp_tdata (rsp_tdata)
   );

endmodule

[rtl/core/cta_ctrl.sv]
// sequencer for the time add/subtract block
`timescale 1ns / 1ps
`include "calendar_time_add_subtract_assert.svh"
module cta_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  cta_pkg::stat_type stat,
   output cta_pkg::cmd_type  cmd
);

   typedef enum logic [3:0] {
      S_IDLE, S_DIVD, S_ADJ, S_CYC, S_STEP, S_DIVH, S_MINI, S_DIVM, S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      valid_ff, valid_in;
   logic      out_free;

   assign out_free   = !valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = valid_ff;

   // command decode and next state
   always_comb begin
      cmd      = '0;
      cmd.div_sel = cta_pkg::DIV_DAY;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_DIVD;
            end
         end
         S_DIVD: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) state_in = S_ADJ;
         end
         S_ADJ: begin
            cmd.adj  = 1'b1;
            state_in = S_CYC;
         end
         S_CYC: begin
            if (stat.cyc_more) cmd.cyc = 1'b1;
            else state_in = S_STEP;
         end
         S_STEP: begin
            if (stat.step_more) begin
               cmd.step = 1'b1;
            end else begin
               cmd.hr_init = 1'b1;
               state_in    = S_DIVH;
            end
         end
         S_DIVH: begin
            cmd.div_step = 1'b1;
            cmd.div_sel  = cta_pkg::DIV_HR;
            if (stat.div_last) state_in = S_MINI;
         end
         S_MINI: begin
            cmd.mn_init = 1'b1;
            state_in    = S_DIVM;
         end
         S_DIVM: begin
            cmd.div_step = 1'b1;
            cmd.div_sel  = cta_pkg::DIV_MIN;
            if (stat.div_last) state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // output valid tracking
   always_comb begin
      valid_in = valid_ff;
      if (rsp_tready) valid_in = 1'b0;
      if (cmd.out_load) valid_in = 1'b1;
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   `CTA_ASSERT_IMP(a_load_free, clock, reset, cmd.out_load, out_free)
   `CTA_ASSERT_NXT(a_accept_div, clock, reset, req_tvalid && req_tready, state_ff == S_DIVD)
   `CTA_ASSERT_NXT(a_load_valid, clock, reset, cmd.out_load, valid_ff)

endmodule

[rtl/core/cta_dp.sv]
// datapath: field clamp, shared constant divider, day stepper and result register
`timescale 1ns / 1ps
`include "calendar_time_add_subtract_assert.svh"
module cta_dp (
   input  logic                           clock,
   input  logic                           reset,
   input  cta_pkg::cmd_type               cmd,
   output cta_pkg::stat_type              stat,
   input  logic                           req_tuser,
   input  logic [cta_pkg::ReqDataW-1:0]   req_tdata,
   output logic [cta_pkg::RspDataW-1:0]   rsp_tdata
);

   logic        op_ff, op_in;
   logic [15:0] yr_ff, yr_in;
   logic [3:0]  mon_ff, mon_in;
   logic [4:0]  day_ff, day_in;
   logic [2:0]  wd_ff, wd_in;
   logic [16:0] tod_ff, tod_in;
   logic [16:0] days_ff, days_in;
   logic [31:0] num_ff, num_in;
   logic [15:0] quo_ff, quo_in;
   logic        cnt_ff, cnt_in;
   logic [4:0]  hr_ff, hr_in;
   logic [cta_pkg::RspDataW-1:0] out_ff, out_in;

   // clamped input fields
   logic [3:0]  c_mon;
   logic [4:0]  c_day, c_hr, dim;
   logic [2:0]  c_wd;
   logic [5:0]  c_mn, c_sc;
   logic [15:0] f_yr;
   logic [3:0]  f_mon;
   logic [4:0]  f_day, f_hr;
   logic [2:0]  f_wd;
   logic [5:0]  f_mn, f_sc;

   assign f_yr  = req_tdata[47:32];
   assign f_mon = req_tdata[51:48];
   assign f_day = req_tdata[56:52];
   assign f_wd  = req_tdata[59:57];
   assign f_hr  = req_tdata[64:60];
   assign f_mn  = req_tdata[70:65];
   assign f_sc  = req_tdata[76:71];

   always_comb begin
      c_mon = (f_mon == 4'd0) ? 4'd1 : ((f_mon > 4'd12) ? 4'd12 : f_mon);
      dim   = cta_pkg::month_len(c_mon, f_yr);
      c_day = (f_day == 5'd0) ? 5'd1 : ((f_day > dim) ? dim : f_day);
      c_wd  = (f_wd > 3'd6) ? 3'd0 : f_wd;
      c_hr  = (f_hr > 5'd23) ? 5'd23 : f_hr;
      c_mn  = (f_mn > 6'd59) ? 6'd59 : f_mn;
      c_sc  = (f_sc > 6'd59) ? 6'd59 : f_sc;
   end

   // shared divider: reciprocal multiply for the quotient, then multiply back for the rest
   logic [16:0] div_d;
   logic [50:0] prod_day;
   logic [26:0] prod_hr;
   logic [20:0] prod_min;
   logic [15:0] quo_est;
   logic [31:0] quo_back;
   always_comb begin
      prod_day = {26'd0, num_ff[31:7]} * {25'd0, cta_pkg::RecipDay};
      prod_hr  = {14'd0, num_ff[16:4]} * {13'd0, cta_pkg::RecipHour};
      prod_min = {11'd0, num_ff[11:2]} * {10'd0, cta_pkg::RecipMin};
      case (cmd.div_sel)
         cta_pkg::DIV_DAY: begin
            div_d   = cta_pkg::SecsPerDay;
            quo_est = prod_day[50:35];
         end
         cta_pkg::DIV_HR: begin
            div_d   = cta_pkg::SecsPerHour;
            quo_est = {10'd0, prod_hr[26:21]};
         end
         cta_pkg::DIV_MIN: begin
            div_d   = cta_pkg::SecsPerMin;
            quo_est = {9'd0, prod_min[20:14]};
         end
         default: begin
            div_d   = cta_pkg::SecsPerMin;
            quo_est = {9'd0, prod_min[20:14]};
         end
      endcase
      quo_back = {16'd0, quo_ff} * {15'd0, div_d};
   end

   // remainder merge into the time of day
   logic [17:0] sum_tod;
   logic [16:0] rem17;
   assign rem17   = num_ff[16:0];
   assign sum_tod = {1'b0, tod_ff} + {1'b0, rem17};

   // day stepping
   logic [4:0]  cur_len, prev_len;
   logic [3:0]  prev_mon;
   logic [15:0] prev_yr;
   always_comb begin
      cur_len  = cta_pkg::month_len(mon_ff, yr_ff);
      prev_mon = (mon_ff > 4'd1) ? mon_ff - 4'd1 : 4'd12;
      prev_yr  = (mon_ff > 4'd1) ? yr_ff : yr_ff - 16'd1;
      prev_len = cta_pkg::month_len(prev_mon, prev_yr);
   end

   logic [4:0] hr_t;
   logic [5:0] mn_t;
   assign mn_t = quo_ff[5:0];
   assign hr_t = hr_ff;

   always_comb begin
      op_in = op_ff; yr_in = yr_ff; mon_in = mon_ff; day_in = day_ff; wd_in = wd_ff;
      tod_in = tod_ff; days_in = days_ff; num_in = num_ff; quo_in = quo_ff;
      cnt_in = cnt_ff; hr_in = hr_ff; out_in = out_ff;
      if (cmd.load) begin
         op_in  = req_tuser;
         yr_in  = f_yr;  mon_in = c_mon; day_in = c_day; wd_in = c_wd;
         tod_in = 17'(c_hr) * 17'd3600 + 17'(c_mn) * 17'd60 + 17'(c_sc);
         num_in = req_tdata[31:0];
         quo_in = '0;
         cnt_in = 1'b1;
      end
      // first step takes the quotient, second leaves the remainder in num
      if (cmd.div_step) begin
         if (cnt_ff) quo_in = quo_est;
         else num_in = num_ff - quo_back;
         cnt_in = 1'b0;
      end
      if (cmd.adj) begin
         if (op_ff == cta_pkg::OP_ADD) begin
            if (sum_tod >= {1'b0, cta_pkg::SecsPerDay}) begin
               tod_in  = 17'(sum_tod - {1'b0, cta_pkg::SecsPerDay});
               days_in = {1'b0, quo_ff} + 17'd1;
            end else begin
               tod_in  = sum_tod[16:0];
               days_in = {1'b0, quo_ff};
            end
         end else begin
            if (rem17 > tod_ff) begin
               tod_in  = 17'({1'b0, tod_ff} + {1'b0, cta_pkg::SecsPerDay} - {1'b0, rem17});
               days_in = {1'b0, quo_ff} + 17'd1;
            end else begin
               tod_in  = tod_ff - rem17;
               days_in = {1'b0, quo_ff};
            end
         end
      end
      if (cmd.cyc) begin
         days_in = days_ff - cta_pkg::DaysPerCyc;
         if (op_ff == cta_pkg::OP_ADD) begin
            yr_in = yr_ff + 16'd4;
            wd_in = (wd_ff >= 3'd2) ? wd_ff - 3'd2 : wd_ff + 3'd5;
         end else begin
            yr_in = yr_ff - 16'd4;
            wd_in = (wd_ff >= 3'd5) ? wd_ff - 3'd5 : wd_ff + 3'd2;
         end
      end
      if (cmd.step) begin
         days_in = days_ff - 17'd1;
         if (op_ff == cta_pkg::OP_ADD) begin
            wd_in = (wd_ff == 3'd6) ? 3'd0 : wd_ff + 3'd1;
            if (day_ff >= cur_len) begin
               day_in = 5'd1;
               if (mon_ff == 4'd12) begin
                  mon_in = 4'd1;
                  yr_in  = yr_ff + 16'd1;
               end else begin
                  mon_in = mon_ff + 4'd1;
               end
            end else begin
               day_in = day_ff + 5'd1;
            end
         end else begin
            wd_in = (wd_ff == 3'd0) ? 3'd6 : wd_ff - 3'd1;
            if (day_ff > 5'd1) begin
               day_in = day_ff - 5'd1;
            end else begin
               mon_in = prev_mon;
               yr_in  = prev_yr;
               day_in = prev_len;
            end
         end
      end
      if (cmd.hr_init) begin
         num_in = {15'd0, tod_ff};
         quo_in = '0;
         cnt_in = 1'b1;
      end
      if (cmd.mn_init) begin
         hr_in  = quo_ff[4:0];
         quo_in = '0;
         cnt_in = 1'b1;
      end
      if (cmd.out_load) begin
         out_in = {6'd0,
                   (hr_t > 5'd12) ? 4'(hr_t - 5'd12) : hr_t[3:0],
                   (hr_t > 5'd12),
                   num_ff[5:0], mn_t, hr_t, wd_ff, day_ff, mon_ff, yr_ff};
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in; yr_ff <= yr_in; mon_ff <= mon_in; day_ff <= day_in; wd_ff <= wd_in;
      tod_ff <= tod_in; days_ff <= days_in; num_ff <= num_in; quo_ff <= quo_in;
      cnt_ff <= cnt_in; hr_ff <= hr_in; out_ff <= out_in;
   end

   assign stat.div_last  = !cnt_ff;
   assign stat.cyc_more  = (days_ff >= cta_pkg::DaysPerCyc);
   assign stat.step_more = (days_ff != 17'd0);
   assign rsp_tdata      = out_ff;

   `CTA_ASSERT_IMP(a_step_done, clock, reset, cmd.hr_init, days_ff == 17'd0)
   `CTA_ASSERT_IMP(a_hour_range, clock, reset, cmd.mn_init, quo_ff < 16'd24)
   `CTA_ASSERT_NXT(a_tod_range, clock, reset, cmd.adj, tod_ff < cta_pkg::SecsPerDay)

endmodule

[bench/calendar_time_add_subtract_tb.sv]
// testbench for the calendar time add/subtract block: directed and random items
`timescale 1ns / 1ps
module calendar_time_add_subtract_tb;

   localparam int CycleLimit = 3000000;

   typedef struct packed {
      logic [15:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [2:0]  weekday;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic        pm;
      logic [3:0]  hour12;
   } moment_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic req_tuser = 1'b0;
   logic [cta_pkg::ReqDataW-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [cta_pkg::RspDataW-1:0] rsp_tdata;

   moment_type expected_moments[$];
   int error_count = 0;
   int sent_count = 0;
   int got_count = 0;
   int cycle_count = 0;
   int stall_left = 0;

   calendar_time_add_subtract uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tuser(req_tuser), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always #5 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("FAIL calendar_time_add_subtract");
         $finish;
      end
   end

   function automatic logic [4:0] days_in_month(logic [3:0] mon, logic [15:0] yr);
      if (mon == 4'd2) return (yr[1:0] == 2'd0) ? 5'd29 : 5'd28;
      if (mon == 4'd4 || mon == 4'd6 || mon == 4'd9 || mon == 4'd11) return 5'd30;
      return 5'd31;
   endfunction

   // moves the time point, after clamping the input fields into range
   function automatic moment_type move_moment(cta_pkg::op_type op, logic [31:0] delta,
                                              logic [15:0] yr_i, logic [3:0] mon_i,
                                              logic [4:0] day_i, logic [2:0] wd_i,
                                              logic [4:0] hr_i, logic [5:0] mn_i,
                                              logic [5:0] sc_i);
      moment_type m;
      logic [15:0] yr;
      logic [3:0] mon;
      logic [4:0] day;
      int unsigned wd, hr, mn, sc, tod, days, rem;
      yr = yr_i; mon = mon_i; day = day_i; wd = wd_i;
      hr = hr_i; mn = mn_i; sc = sc_i;
      if (mon < 1) mon = 1;
      if (mon > 12) mon = 12;
      if (day < 1) day = 1;
      if (day > days_in_month(mon, yr)) day = days_in_month(mon, yr);
      if (wd > 6) wd = 0;
      if (hr > 23) hr = 23;
      if (mn > 59) mn = 59;
      if (sc > 59) sc = 59;
      tod = hr * 3600 + mn * 60 + sc;
      days = delta / 86400;
      rem = delta % 86400;
      if (op == cta_pkg::OP_ADD) begin
         tod += rem;
         if (tod >= 86400) begin
            tod -= 86400;
            days++;
         end
         while (days >= 1461) begin
            days -= 1461; yr = yr + 16'd4; wd = (wd + 5) % 7;
         end
         while (days > 0) begin
            if (day >= days_in_month(mon, yr)) begin
               day = 1;
               if (mon == 12) begin
                  mon = 1; yr = yr + 16'd1;
               end else begin
                  mon++;
               end
            end else begin
               day++;
            end
            wd = (wd == 6) ? 0 : wd + 1;
            days--;
         end
      end else begin
         if (rem > tod) begin
            tod = tod + 86400 - rem;
            days++;
         end else begin
            tod -= rem;
         end
         while (days >= 1461) begin
            days -= 1461; yr = yr - 16'd4; wd = (wd + 2) % 7;
         end
         while (days > 0) begin
            if (day > 1) begin
               day--;
            end else begin
               if (mon > 1) begin
                  mon--;
               end else begin
                  mon = 12; yr = yr - 16'd1;
               end
               day = days_in_month(mon, yr);
            end
            wd = (wd == 0) ? 6 : wd - 1;
            days--;
         end
      end
      hr = tod / 3600;
      m.year = yr; m.month = mon; m.day = day; m.weekday = wd[2:0];
      m.hour = hr[4:0];
      m.minute = 6'((tod % 3600) / 60);
      m.second = 6'(tod % 60);
      m.pm = (hr > 12);
      m.hour12 = 4'((hr > 12) ? hr - 12 : hr);
      return m;
   endfunction

   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   // sends one item and records its expected result
   task automatic send_item(cta_pkg::op_type op, logic [31:0] delta, logic [15:0] yr,
                            logic [3:0] mon, logic [4:0] day, logic [2:0] wd,
                            logic [4:0] hr, logic [5:0] mn, logic [5:0] sc);
      int gap;
      gap = gap_length();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {3'b0, sc, mn, hr, wd, day, mon, yr, delta};
      expected_moments.push_back(move_moment(op, delta, yr, mon, day, wd, hr, mn, sc));
      do @(posedge clock); while (!req_tready);
      sent_count++;
   endtask

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch on %s: got %0d, expected %0d", what, got, want);
      error_count++;
   endtask

   // output stall pattern
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_tready <= 1'b1;
         stall_left <= gap_length();
      end
   end

   // result check
   always @(posedge clock) begin
      moment_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tdata[15:0], rsp_tdata[19:16], rsp_tdata[24:20], rsp_tdata[27:25],
                rsp_tdata[32:28], rsp_tdata[38:33], rsp_tdata[44:39], rsp_tdata[45],
                rsp_tdata[49:46]};
         got_count++;
         if (expected_moments.size() == 0) begin
            report_mismatch("result count", got_count, sent_count);
         end else begin
            want = expected_moments.pop_front();
            if (got.year != want.year) report_mismatch("year", got.year, want.year);
            if (got.month != want.month) report_mismatch("month", got.month, want.month);
            if (got.day != want.day) report_mismatch("day", got.day, want.day);
            if (got.weekday != want.weekday)
               report_mismatch("weekday", got.weekday, want.weekday);
            if (got.hour != want.hour) report_mismatch("hour", got.hour, want.hour);
            if (got.minute != want.minute) report_mismatch("minute", got.minute, want.minute);
            if (got.second != want.second) report_mismatch("second", got.second, want.second);
            if (got.pm != want.pm) report_mismatch("pm flag", got.pm, want.pm);
            if (got.hour12 != want.hour12)
               report_mismatch("twelve-hour", got.hour12, want.hour12);
         end
      end
   end

   // field extremes, both commands and clamping of out-of-range fields
   task automatic test_directed();
      send_item(cta_pkg::OP_ADD, 32'd0, 16'd2024, 4'd2, 5'd29, 3'd4, 5'd0, 6'd0, 6'd0);
      send_item(cta_pkg::OP_ADD, 32'hFFFF_FFFF, 16'd0, 4'd1, 5'd1, 3'd0, 5'd0, 6'd0, 6'd0);
      send_item(cta_pkg::OP_SUB, 32'hFFFF_FFFF, 16'd0, 4'd1, 5'd1, 3'd0, 5'd0, 6'd0, 6'd0);
      send_item(cta_pkg::OP_ADD, 32'd1, 16'hFFFF, 4'd12, 5'd31, 3'd6, 5'd23, 6'd59, 6'd59);
      send_item(cta_pkg::OP_SUB, 32'd1, 16'd0, 4'd1, 5'd1, 3'd0, 5'd0, 6'd0, 6'd0);
      send_item(cta_pkg::OP_ADD, 32'd86400, 16'd2023, 4'd2, 5'd28, 3'd2, 5'd12, 6'd0, 6'd0);
      send_item(cta_pkg::OP_SUB, 32'd86400, 16'd2024, 4'd3, 5'd1, 3'd5, 5'd13, 6'd0, 6'd0);
      send_item(cta_pkg::OP_ADD, 32'd3600, 16'd100, 4'd0, 5'd0, 3'd7, 5'd31, 6'd63, 6'd63);
      send_item(cta_pkg::OP_SUB, 32'd59, 16'd7, 4'd15, 5'd31, 3'd7, 5'd24, 6'd60, 6'd60);
      send_item(cta_pkg::OP_ADD, 32'd0, 16'd2021, 4'd4, 5'd31, 3'd1, 5'd11, 6'd30, 6'd30);
      send_item(cta_pkg::OP_ADD, 32'd0, 16'd2021, 4'd2, 5'd30, 3'd1, 5'd12, 6'd1, 6'd1);
      send_item(cta_pkg::OP_SUB, 32'd126230400, 16'd3, 4'd6, 5'd15, 3'd3,
                5'd1, 6'd2, 6'd3);
      send_item(cta_pkg::OP_ADD, 32'd126230400, 16'hFFFE, 4'd6, 5'd15, 3'd3,
                5'd22, 6'd2, 6'd3);
      send_item(cta_pkg::OP_SUB, 32'h8000_0000, 16'h8000, 4'd8, 5'd16, 3'd4,
                5'd16, 6'd32, 6'd32);
      send_item(cta_pkg::OP_ADD, 32'd43199, 16'h5555, 4'd9, 5'd10, 3'd2,
                5'd10, 6'd10, 6'd10);
   endtask

   // random points, mostly valid with some out-of-range fields, with mostly modest second counts
   task automatic test_random();
      logic [31:0] delta;
      logic [3:0] mon;
      logic [15:0] yr;
      for (int i = 0; i < 100; i++) begin
         yr = $urandom;
         mon = $urandom_range(1, 12);
         case ($urandom_range(0, 9))
            0: delta = $urandom;
            1, 2: delta = $urandom_range(0, 200000000);
            3: delta = $urandom_range(0, 100000);
            default: delta = $urandom_range(0, 10000000);
         endcase
         if ($urandom_range(0, 9) == 0) begin
            send_item(cta_pkg::op_type'($urandom_range(0, 1)), delta, yr, 4'($urandom),
                      5'($urandom), 3'($urandom), 5'($urandom), 6'($urandom),
                      6'($urandom));
         end else begin
            send_item(cta_pkg::op_type'($urandom_range(0, 1)), delta, yr, mon,
                      5'($urandom_range(1, days_in_month(mon, yr))),
                      3'($urandom_range(0, 6)), 5'($urandom_range(0, 23)),
                      6'($urandom_range(0, 59)), 6'($urandom_range(0, 59)));
         end
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random();
      req_tvalid <= 1'b0;
      while (expected_moments.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("sent %0d items, checked %0d results, both commands and clamped fields",
               sent_count, got_count);
      if (error_count == 0) begin
         $display("PASS calendar_time_add_subtract");
      end else begin
         $display("%0d mismatches", error_count);
         $display("FAIL calendar_time_add_subtract");
      end
      $finish;
   end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/cta_pkg.sv
rtl/core/cta_ctrl.sv
rtl/core/cta_dp.sv
rtl/core/calendar_time_add_subtract.sv
bench/calendar_time_add_subtract_tb.sv
